// File: hw/rtl/bwms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwms_pkg
// Shared widths, limits and saturating helpers for the best-window masked
// sum unit.
// ----------------------------------------------------------------------------
package bwms_pkg;

  localparam int unsigned VAL_W = 16;  // input value width
  localparam int unsigned LEN_W = 11;  // window length register width
  localparam int unsigned WS_W  = 26;  // window sum and best gain width
  localparam int unsigned CNT_W = 32;  // item count width
  localparam int unsigned SUM_W = 48;  // base sum and result width

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  // Add two sums and clip at the all-ones value
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// File: hw/rtl/best_window_masked_sum_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_window_masked_sum_unit
// Base sum of flagged values plus the best fixed-length window sum of the
// unflagged values, one result per data set.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries value_i, awake_i, last_i.
//   Flagged (awake) values add to the base sum; unflagged values run through
//   a ring buffer RAM that keeps the sum of the last window_len gains.
//   The beat with last_i set closes the set: one result beat with
//   best_total_o and window_fits_o goes out on (out_valid_o / out_stall_i).
//   Throughput: one beat per cycle while in_stall_o is low. The ring RAM is
//   read at acceptance and written back as the beat leaves the update stage;
//   a same-entry overlap is forwarded. Path: the last beat waits in the
//   update stage, then loads the output register behind the result beat.
//   Stall: the output register holds a pending result; input beats keep
//   flowing until a second last beat reaches the update stage while the
//   first result is still stalled, then in_stall_o rises.
//   Reset: window_len is 1, all sums and counts clear, no result pending.
//   RAM contents are undefined until written; no clearing pass is needed.
//   window_len_we_i writes window_len_i; write it only while idle.
// ----------------------------------------------------------------------------
module best_window_masked_sum_unit #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        window_len_we_i,
  input  logic [bwms_pkg::LEN_W-1:0]  window_len_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bwms_pkg::VAL_W-1:0]  value_i,
  input  logic                        awake_i,
  input  logic                        last_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bwms_pkg::SUM_W-1:0]  best_total_o,
  output logic                        window_fits_o
);

  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW = ((AW > bwms_pkg::LEN_W) ? AW : bwms_pkg::LEN_W) + 1;

  // configuration and front state
  logic [bwms_pkg::LEN_W-1:0] window_len_q;
  logic [bwms_pkg::LEN_W-1:0] len_w;
  logic [AW-1:0]              ptr_q, ptr_d;
  logic [bwms_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic [AW-1:0]              addr_w;
  logic [CW-1:0]              addr_inc;
  logic                       sub_en_w, fit_w, fwd_w;
  logic                       in_accept;

  // update stage
  logic                       s2_valid_q;
  logic [bwms_pkg::VAL_W-1:0] s2_value_q;
  logic [bwms_pkg::VAL_W-1:0] s2_gain_q;
  logic                       s2_awake_q, s2_last_q, s2_sub_q, s2_fit_q, s2_fwd_q;
  logic [AW-1:0]              s2_addr_q;
  logic [bwms_pkg::VAL_W-1:0] fwd_gain_q;
  logic                       s2_adv;

  // accumulated sums
  logic [bwms_pkg::WS_W-1:0]  ws_q, ws_d, ws_sub, ws_new;
  logic [bwms_pkg::WS_W-1:0]  best_q, best_d, best_new;
  logic [bwms_pkg::SUM_W-1:0] base_q, base_d, base_new;
  logic [bwms_pkg::VAL_W-1:0] ram_rdata, leaving;

  // output register
  logic                       out_valid_q;
  logic [bwms_pkg::SUM_W-1:0] obase_q;
  logic [bwms_pkg::WS_W-1:0]  obest_q;
  logic                       ofit_q;

  // Clamp the window length to 1..MAX_WINDOW
  always_comb begin
    priority if (window_len_q == '0) begin
      len_w = bwms_pkg::LEN_W'(1);
    end else if (32'(window_len_q) > 32'(MAX_WINDOW)) begin
      len_w = bwms_pkg::LEN_W'(MAX_WINDOW);
    end else begin
      len_w = window_len_q;
    end
  end

  // Front: ring address, item count, forward check
  assign in_stall_o = s2_valid_q && !s2_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    addr_w   = (CW'(ptr_q) >= CW'(len_w)) ? '0 : ptr_q;
    addr_inc = CW'(addr_w) + CW'(1);
    ptr_d    = (addr_inc >= CW'(len_w)) ? '0 : addr_inc[AW-1:0];
    cnt_inc  = (cnt_q == bwms_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;
    sub_en_w = cnt_q >= bwms_pkg::CNT_W'(len_w);
    fit_w    = cnt_inc >= bwms_pkg::CNT_W'(len_w);
    fwd_w    = s2_valid_q && (s2_addr_q == addr_w);
    cnt_d    = last_i ? '0 : cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= bwms_pkg::LEN_RESET;
      ptr_q        <= '0;
      cnt_q        <= '0;
      s2_valid_q   <= 1'b0;
    end else begin
      if (window_len_we_i) begin
        window_len_q <= window_len_i;
      end
      if (in_accept) begin
        ptr_q <= last_i ? '0 : ptr_d;
        cnt_q <= cnt_d;
      end
      if (in_accept) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // Hold the beat for the update stage
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s2_value_q <= value_i;
      s2_gain_q  <= awake_i ? '0 : value_i;
      s2_awake_q <= awake_i;
      s2_last_q  <= last_i;
      s2_sub_q   <= sub_en_w;
      s2_fit_q   <= fit_w;
      s2_fwd_q   <= fwd_w;
      s2_addr_q  <= addr_w;
      fwd_gain_q <= s2_gain_q;
    end
  end

  // Ring buffer of gains
  bwms_ram #(
    .WIDTH (bwms_pkg::VAL_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (s2_adv),
    .waddr_i (s2_addr_q),
    .wdata_i (s2_gain_q),
    .re_i    (in_accept),
    .raddr_i (addr_w),
    .rdata_o (ram_rdata)
  );

  // Update: drop the leaving gain, add the new one, track the best
  always_comb begin
    leaving  = s2_fwd_q ? fwd_gain_q : ram_rdata;
    if (s2_sub_q) begin
      ws_sub = (ws_q >= bwms_pkg::WS_W'(leaving)) ? ws_q - bwms_pkg::WS_W'(leaving) : '0;
    end else begin
      ws_sub = ws_q;
    end
    ws_new   = ws_sub + bwms_pkg::WS_W'(s2_gain_q);
    best_new = (s2_fit_q && (ws_new > best_q)) ? ws_new : best_q;
    base_new = s2_awake_q ? bwms_pkg::sat_add(base_q, bwms_pkg::SUM_W'(s2_value_q))
                          : base_q;
    ws_d     = s2_last_q ? '0 : ws_new;
    best_d   = s2_last_q ? '0 : best_new;
    base_d   = s2_last_q ? '0 : base_new;
  end

  assign s2_adv = s2_valid_q && (!s2_last_q || !out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= '0;
      best_q      <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_adv) begin
        ws_q   <= ws_d;
        best_q <= best_d;
        base_q <= base_d;
      end
      if (s2_adv && s2_last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result beat
  always_ff @(posedge clk_i) begin
    if (s2_adv && s2_last_q) begin
      obase_q <= base_new;
      obest_q <= best_new;
      ofit_q  <= s2_fit_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign best_total_o  = bwms_pkg::sat_add(obase_q, bwms_pkg::SUM_W'(obest_q));
  assign window_fits_o = ofit_q;

`ifndef SYNTHESIS
  a_ptr_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (CW'(ptr_q) < CW'($past(len_w))))
    else $error("ring pointer left the window");

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_i) |=> (cnt_q == '0) && (ptr_q == '0))
    else $error("set state not cleared after last beat");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_adv && s2_last_q) |-> (!out_valid_q || !out_stall_i))
    else $error("pending result overwritten");

  a_fwd_has_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && fwd_w |=> s2_valid_q && s2_fwd_q)
    else $error("forward taken without a prior beat");
`endif

endmodule

// File: hw/rtl/bwms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwms_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. A read of the address being written returns old data.
// ----------------------------------------------------------------------------
module bwms_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sim/best_window_masked_sum_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_window_masked_sum_unit_test
// Self-checking bench for the best-window masked sum unit. A short table of
// beats covers the extremes, then random data sets under three idling modes,
// a long receiver hold-off and one set that wraps a long window. Each accepted
// beat runs through a local copy of the set arithmetic; results are matched in
// order against the queue of expected set totals.
// ----------------------------------------------------------------------------
module best_window_masked_sum_unit_test;

  localparam int unsigned RING_DEPTH  = 1024;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned PHASE_BEATS = 140;
  localparam int unsigned N_ROWS      = 22;

  typedef struct packed {
    logic [bwms_pkg::SUM_W-1:0] total;
    logic                       fits;
  } set_result_t;

  typedef struct packed {
    logic                       set_len;
    logic [bwms_pkg::LEN_W-1:0] wlen;
    logic [bwms_pkg::VAL_W-1:0] value;
    logic                       awake;
    logic                       is_last;
    logic                       known;
    logic [bwms_pkg::SUM_W-1:0] total;
    logic                       fits;
  } step_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       window_len_we_i;
  logic [bwms_pkg::LEN_W-1:0] window_len_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [bwms_pkg::VAL_W-1:0] value_i;
  logic                       awake_i;
  logic                       last_i;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [bwms_pkg::SUM_W-1:0] best_total_o;
  logic                       window_fits_o;

  // Local copy of the set state
  logic [bwms_pkg::LEN_W-1:0] cfg_window_len;
  logic [bwms_pkg::VAL_W-1:0] gain_mem [RING_DEPTH];
  int unsigned                ring_slot;
  logic [bwms_pkg::SUM_W-1:0] flagged_sum;
  logic [bwms_pkg::WS_W-1:0]  run_gain;
  logic [bwms_pkg::WS_W-1:0]  peak_gain;
  logic [bwms_pkg::CNT_W-1:0] set_beats;

  set_result_t pending_results [$];
  step_row_t   opening_rows [N_ROWS];

  int unsigned fail_count   = 0;
  int unsigned beats_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned hold_asks    = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;

  best_window_masked_sum_unit #(
    .MAX_WINDOW(RING_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .window_len_we_i(window_len_we_i),
    .window_len_i   (window_len_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (value_i),
    .awake_i        (awake_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .best_total_o   (best_total_o),
    .window_fits_o  (window_fits_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Clamp the register to the usable window range
  function automatic int unsigned span_of(input logic [bwms_pkg::LEN_W-1:0] len);
    if (len == '0) return 1;
    if (len > RING_DEPTH) return RING_DEPTH;
    return 32'(len);
  endfunction

  // Clear the sums for the next data set
  function automatic void open_new_set();
    ring_slot   = 0;
    flagged_sum = '0;
    run_gain    = '0;
    peak_gain   = '0;
    set_beats   = '0;
  endfunction

  // Advance the set state by one beat; report the set total on the last beat
  function automatic void predict_beat(input logic [bwms_pkg::VAL_W-1:0] v,
                                       input logic aw, input logic lst,
                                       output bit closes, output set_result_t res);
    int unsigned                span;
    logic [bwms_pkg::VAL_W-1:0] gain;
    logic [bwms_pkg::VAL_W-1:0] leaving;
    logic [bwms_pkg::SUM_W:0]   wide;
    span = span_of(cfg_window_len);
    gain = aw ? '0 : v;
    if (aw) begin
      wide = {1'b0, flagged_sum} + (bwms_pkg::SUM_W + 1)'(v);
      flagged_sum = wide[bwms_pkg::SUM_W] ? bwms_pkg::SUM_MAX : wide[bwms_pkg::SUM_W-1:0];
    end
    if (ring_slot >= span) ring_slot = 0;
    // Drop the gain that leaves the window once it is full
    if (set_beats >= span) begin
      leaving  = gain_mem[ring_slot];
      run_gain = (run_gain >= leaving) ? run_gain - leaving : '0;
    end
    run_gain = run_gain + gain;
    gain_mem[ring_slot] = gain;
    ring_slot = (ring_slot + 1 >= span) ? 0 : ring_slot + 1;
    if (set_beats != bwms_pkg::CNT_MAX) set_beats = set_beats + 1'b1;
    if (set_beats >= span && run_gain > peak_gain) peak_gain = run_gain;
    closes = lst;
    res    = '0;
    if (lst) begin
      wide = {1'b0, flagged_sum} + (bwms_pkg::SUM_W + 1)'(peak_gain);
      res.total = wide[bwms_pkg::SUM_W] ? bwms_pkg::SUM_MAX : wide[bwms_pkg::SUM_W-1:0];
      res.fits  = (set_beats >= span);
      open_new_set();
    end
  endfunction

  // Weight the extremes of the value range
  function automatic logic [bwms_pkg::VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return bwms_pkg::VAL_W'($urandom_range(16'hFFFF));
  endfunction

  // Mostly short windows, with the out-of-range values now and then
  function automatic logic [bwms_pkg::LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return bwms_pkg::LEN_W'($urandom_range(1, 8));
    if (r < 80) return bwms_pkg::LEN_W'($urandom_range(9, 40));
    if (r < 88) return '0;
    if (r < 93) return '1;
    return bwms_pkg::LEN_W'($urandom_range(2047));
  endfunction

  // Sets around a short window length so that both fits and misses occur; short sets for long windows
  function automatic int unsigned pick_set_size();
    int unsigned span;
    span = span_of(cfg_window_len);
    if (span <= 40) return $urandom_range(1, 2 * span + 3);
    return $urandom_range(1, 12);
  endfunction

  // Offer one beat, hold it until accepted, then record what it should cause
  task automatic send_beat(input logic [bwms_pkg::VAL_W-1:0] v, input logic aw,
                           input logic lst, input bit typed, input set_result_t typed_res);
    bit          closes;
    set_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    awake_i    <= aw;
    last_i     <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_beat(v, aw, lst, closes, res);
    if (closes) pending_results.push_back(typed ? typed_res : res);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every expected result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write the window length while the unit is idle
  task automatic load_window_len(input logic [bwms_pkg::LEN_W-1:0] len);
    settle();
    repeat (4) @(negedge clk_i);
    window_len_we_i <= 1'b1;
    window_len_i    <= len;
    @(negedge clk_i);
    window_len_we_i <= 1'b0;
    cfg_window_len   = len;
  endtask

  task automatic send_random_set(input int unsigned size);
    int unsigned awake_pct;
    awake_pct = $urandom_range(4) * 25;
    for (int unsigned i = 0; i < size; i++) begin
      send_beat(pick_value(), $urandom_range(99) < awake_pct, i == size - 1, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Check each result beat against the oldest expected set total
  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: best_total %0d window_fits %0d",
               best_total_o, window_fits_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (best_total_o !== want.total) begin
          $error("best_total: expected %0d, got %0d", want.total, best_total_o);
          fail_count++;
        end
        if (window_fits_o !== want.fits) begin
          $error("window_fits: expected %0d, got %0d", want.fits, window_fits_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    window_len_we_i = 1'b0;
    window_len_i    = '0;
    in_valid_i      = 1'b0;
    value_i         = '0;
    awake_i         = 1'b0;
    last_i          = 1'b0;
    cfg_window_len  = bwms_pkg::LEN_RESET;
    open_new_set();

    // set_len, wlen, value, awake, last, known, total, fits
    opening_rows = '{
      // window of one after reset: lone flagged max, lone unflagged max, zero
      '{1'b0, 11'd0,    16'hFFFF, 1'b1, 1'b1, 1'b1, 48'd65535, 1'b1},
      '{1'b0, 11'd0,    16'hFFFF, 1'b0, 1'b1, 1'b1, 48'd65535, 1'b1},
      '{1'b0, 11'd0,    16'h0000, 1'b0, 1'b1, 1'b1, 48'd0,     1'b1},
      // window of four, set too short: base only, no fit
      '{1'b1, 11'd4,    16'd100,  1'b1, 1'b0, 1'b0, 48'd0,     1'b0},
      '{1'b0, 11'd0,    16'd5,    1'b0, 1'b0, 1'b0, 48'd0,     1'b0},
      '{1'b0, 11'd0,    16'd7,    1'b0, 1'b1, 1'b1, 48'd100,   1'b0},
      // window of four over alternating bit patterns
      '{1'b0, 11'd0,    16'hAAAA, 1'b0, 1'b0, 1'b0, 48'd0,     1'b0},
      '{1'b0, 11'd0,    16'h5555, 1'b1, 1'b0, 1'b0, 48'd0,     1'b0},
      '{1'b0, 11'd0,    16'hFFFF, 1'b0, 1'b0, 1'b0, 48'd0,     1'b0},
      '{1'b0, 11'd0,    16'h0001, 1'b0, 1'b0, 1'b0, 48'd0,     1'b0},
      '{1'b0, 11'd0,    16'h8000, 1'b0, 1'b0, 1'b0, 48'd0,     1'b0},
      '{1'b0, 11'd0,    16'h7FFF, 1'b1, 1'b1, 1'b0, 48'd0,     1'b0},
      // zero length acts as one
      '{1'b1, 11'd0,    16'd9,    1'b0, 1'b0, 1'b0, 48'd0,     1'b0},
      '{1'b0, 11'd0,    16'd3,    1'b1, 1'b1, 1'b1, 48'd12,    1'b1},
      // all-ones length acts as the ring depth: far too few beats
      '{1'b1, 11'h7FF,  16'd1,    1'b1, 1'b0, 1'b0, 48'd0,     1'b0},
      '{1'b0, 11'd0,    16'hFFFF, 1'b0, 1'b0, 1'b0, 48'd0,     1'b0},
      '{1'b0, 11'd0,    16'd2,    1'b1, 1'b1, 1'b1, 48'd3,     1'b0},
      // window of three sliding over five beats, best at the last position
      '{1'b1, 11'd3,    16'd10,   1'b0, 1'b0, 1'b0, 48'd0,     1'b0},
      '{1'b0, 11'd0,    16'd20,   1'b0, 1'b0, 1'b0, 48'd0,     1'b0},
      '{1'b0, 11'd0,    16'd30,   1'b0, 1'b0, 1'b0, 48'd0,     1'b0},
      '{1'b0, 11'd0,    16'd1,    1'b0, 1'b0, 1'b0, 48'd0,     1'b0},
      '{1'b0, 11'd0,    16'd50,   1'b0, 1'b1, 1'b0, 48'd0,     1'b0}
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    for (int i = 0; i < N_ROWS; i++) begin
      if (opening_rows[i].set_len) load_window_len(opening_rows[i].wlen);
      send_beat(opening_rows[i].value, opening_rows[i].awake, opening_rows[i].is_last,
                opening_rows[i].known, {opening_rows[i].total, opening_rows[i].fits});
    end

    // Random sets under each idling mode
    for (int ph = 0; ph < 3; ph++) begin
      int unsigned phase_end;
      tx_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 52 : 0;
      rx_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 25 : 0;
      phase_end   = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        if ($urandom_range(4) == 0) load_window_len(pick_len());
        send_random_set(pick_set_size());
      end
    end

    // Hold the receiver off while short sets keep coming, then drain
    load_window_len(bwms_pkg::LEN_W'($urandom_range(1, 3)));
    hold_asks++;
    repeat (40) send_random_set($urandom_range(1, 3));
    settle();

    // One set that runs just past a long window and wraps it once
    load_window_len(11'd400);
    send_random_set(410);

    settle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
